// ----- sv/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, constants and coil tables for the stepper phase sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int SPR_W      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int POS_W      = 10;
    localparam int STEPS_W    = SPR_W + 1;
    localparam int DRIVE_W    = 6;
    localparam int PEND_W     = 4;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 16;

    localparam logic REQ_STEP = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic DIR_FWD  = 1'b0;

    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_STEP     = CFG_IDX_W'(1);

    localparam logic [SPR_W-1:0]   SPR_RESET   = SPR_W'(20);
    localparam logic               HALF_RESET  = 1'b1;
    localparam logic [DRIVE_W-1:0] DRIVE_RESET = DRIVE_W'(8);
    localparam logic [POS_W-1:0]   POS_RESET   = '1;

    typedef struct packed {
        logic push;
        logic pop;
        logic dir;
    } t_fifo_ctrl;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic              head_dir;
        logic [CNT_W-1:0]  count_next;
    } t_fifo_status;

    function automatic logic [DRIVE_W-1:0] half_pattern(input logic [2:0] phase);
        logic [DRIVE_W-1:0] pat;
        case (phase)
            3'd0:    pat = 6'h1A;
            3'd1:    pat = 6'h18;
            3'd2:    pat = 6'h1C;
            3'd3:    pat = 6'h0C;
            3'd4:    pat = 6'h2C;
            3'd5:    pat = 6'h28;
            3'd6:    pat = 6'h2A;
            default: pat = 6'h0A;
        endcase
        return pat;
    endfunction

    function automatic logic [DRIVE_W-1:0] full_pattern(input logic [1:0] phase);
        logic [DRIVE_W-1:0] pat;
        case (phase)
            2'd0:    pat = 6'h1A;
            2'd1:    pat = 6'h1C;
            2'd2:    pat = 6'h2C;
            default: pat = 6'h2A;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ----- sv/sps_dir_fifo.sv -----
// ----------------------------------------------------------------------------
// sps_dir_fifo
// Direction buffer: one bit per pending step, pushed by step pulses and
// popped by service ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_dir_fifo
    import sps_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_fifo_ctrl   i_ctrl,
    output t_fifo_status      o_status
);

    logic               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_head, n_head;
    logic [FIFO_AW-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               full;
    logic               empty;
    logic               do_push;
    logic               do_pop;

    function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] ptr);
        return (ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : ptr + FIFO_AW'(1);
    endfunction

    assign full    = (r_count == CNT_W'(FIFO_DEPTH));
    assign empty   = (r_count == '0);
    assign do_push = i_ctrl.push && !full;
    assign do_pop  = i_ctrl.pop && !empty;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (do_push) begin
            n_tail  = ptr_inc(r_tail);
            n_count = r_count + CNT_W'(1);
        end else if (do_pop) begin
            n_head  = ptr_inc(r_head);
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_ctrl.dir;
        end
    end

    assign o_status.full       = full;
    assign o_status.empty      = empty;
    assign o_status.head_dir   = r_mem[r_head];
    assign o_status.count_next = n_count;

endmodule

`default_nettype wire

// ----- sv/sps_motion.sv -----
// ----------------------------------------------------------------------------
// sps_motion
// Rotor position counter with wrap at the step count and coil pattern
// lookup for half and full stepping.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_motion
    import sps_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic               i_dir,
    input  wire logic [SPR_W-1:0]   i_steps_per_rev,
    input  wire logic               i_half_step,
    output logic      [DRIVE_W-1:0] o_drive_next
);

    logic signed [POS_W-1:0] r_pos, n_pos;
    logic        [DRIVE_W-1:0] r_drive, n_drive;
    logic        [SPR_W-1:0]   spr_eff;
    logic        [STEPS_W-1:0] steps;
    logic signed [POS_W-1:0]   steps_s;
    logic signed [POS_W-1:0]   pos_inc;
    logic signed [POS_W-1:0]   pos_base;

    always_comb begin
        spr_eff  = (i_steps_per_rev == '0) ? SPR_W'(1) : i_steps_per_rev;
        steps    = i_half_step ? {spr_eff, 1'b0} : {1'b0, spr_eff};
        steps_s  = $signed(POS_W'(steps));
        pos_inc  = r_pos + POS_W'(1);
        pos_base = (r_pos < 0) ? steps_s : r_pos;
        n_pos    = r_pos;
        n_drive  = r_drive;
        if (i_step) begin
            if (i_dir == DIR_FWD) begin
                n_pos = (pos_inc >= steps_s) ? '0 : pos_inc;
            end else begin
                n_pos = pos_base - POS_W'(1);
            end
            n_drive = i_half_step ? half_pattern(n_pos[2:0]) : full_pattern(n_pos[1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_RESET;
            r_drive <= DRIVE_RESET;
        end else begin
            r_pos   <= n_pos;
            r_drive <= n_drive;
        end
    end

    assign o_drive_next = n_drive;

endmodule

`default_nettype wire

// ----- sv/stepper_phase_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_top
// Step/direction stepper phase sequencer with buffered steps.
// ----------------------------------------------------------------------------
// Each input word is either a step pulse (tuser 0), whose direction goes into
// an eight-entry buffer and is dropped when the buffer is full, or a service
// tick (tuser 1), which reports buffer overflow and executes one buffered step if any.
// Every input word gives exactly one output word: the coil pattern now driven,
// the overflow flag and the number of steps still buffered. One word is taken
// per clock while the output is not stalled; each word passes through the input
// register and then the result register. Configuration writes take
// effect on the next step and should be made while no words are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_phase_sequencer_top
    import sps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] direction
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,   // [0] req_type

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] coil_pattern,
                                                       // [6] overflow_error,
                                                       // [10:7] pending_steps

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SPR_W-1:0]     r_steps_per_rev;
    logic                 r_half_step;

    logic                 r_in_valid;
    logic                 r_in_req;
    logic                 r_in_dir;

    logic                 r_out_valid;
    logic [DRIVE_W-1:0]   r_out_coil;
    logic                 r_out_err;
    logic [PEND_W-1:0]    r_out_pend;

    logic                 advance;
    logic                 process;
    logic                 is_tick;
    t_fifo_ctrl           fifo_ctrl;
    t_fifo_status         fifo_status;
    logic [DRIVE_W-1:0]   drive_next;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_per_rev <= SPR_RESET;
            r_half_step     <= HALF_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STEPS_PER_REV: r_steps_per_rev <= i_cfg_data[SPR_W-1:0];
                CFG_HALF_STEP:     r_half_step     <= i_cfg_data[0];
                default:           r_half_step     <= r_half_step;
            endcase
        end
    end

    // pipeline handshake
    assign advance       = !r_out_valid || m_axis_tready;
    assign process       = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req <= s_axis_tuser[0];
            r_in_dir <= s_axis_tdata[0];
        end
    end

    assign is_tick        = (r_in_req == REQ_TICK);
    assign fifo_ctrl.push = process && (r_in_req == REQ_STEP);
    assign fifo_ctrl.pop  = process && is_tick;
    assign fifo_ctrl.dir  = r_in_dir;

    sps_dir_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (fifo_ctrl),
        .o_status (fifo_status)
    );

    sps_motion u_motion (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (fifo_ctrl.pop && !fifo_status.empty),
        .i_dir           (fifo_status.head_dir),
        .i_steps_per_rev (r_steps_per_rev),
        .i_half_step     (r_half_step),
        .o_drive_next    (drive_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_coil <= drive_next;
            r_out_err  <= is_tick && fifo_status.full;
            r_out_pend <= PEND_W'(fifo_status.count_next);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - DRIVE_W - 1 - PEND_W)'(0),
                            r_out_pend, r_out_err, r_out_coil};

endmodule

`default_nettype wire

// ----- sv/sps_checker.sv -----
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks on the stepper phase sequencer result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_checker
    import sps_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed under stall");

    // no result straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // pending count never beyond the buffer depth
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:7] <= PEND_W'(FIFO_DEPTH)))
        else $error("pending count out of range");

    // overflow tick always pops one step from a full buffer
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6] |-> (m_axis_tdata[10:7] == PEND_W'(FIFO_DEPTH - 1)))
        else $error("overflow with wrong pending count");

endmodule

bind stepper_phase_sequencer_top sps_checker u_sps_checker (.*);

`default_nettype wire
